>>> sv/tsvs_pkg.sv
// Shared types and constants of the tab-separated cell splitter.
package tsvs_pkg;

    localparam int DEF_MAX_COLUMNS = 64;
    localparam int DEF_OFFSET_BITS = 24;
    localparam int QUEUE_DEPTH     = 4;

    localparam int OUT_W = 24;
    localparam int ROW_W = 16;
    localparam int COL_W = 6;
    localparam int WID_W = 7;

    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_CR  = 8'h0d;
    localparam logic [7:0] CH_LF  = 8'h0a;

    // One queued run: the cell closed by a byte plus the padding cells after it
    typedef struct packed {
        logic [OUT_W-1:0] head_off;
        logic [OUT_W-1:0] head_len;
        logic [OUT_W-1:0] pad_off;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] head_col;
        logic [COL_W-1:0] pad_col;
        logic [WID_W-1:0] pad_cnt;
        logic             head_rdone;
        logic             ovf;
        logic             eod;
    } t_cmd;

    typedef struct packed {
        logic [OUT_W-1:0] cell_offset;
        logic [OUT_W-1:0] cell_length;
        logic [ROW_W-1:0] row_index;
        logic [COL_W-1:0] column_index;
        logic             row_done;
        logic             file_done;
        logic             overflow;
        logic             run_last;
    } t_result;

endpackage

>>> sv/tsvs_if.sv
// Stream interfaces of the splitter: byte input and cell record output.
interface tsvs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_data;

    modport source (output valid, data_byte, end_of_data, input ready);
    modport sink   (input valid, data_byte, end_of_data, output ready);
endinterface

interface tsvs_out_if;
    import tsvs_pkg::*;
    logic             valid;
    logic             ready;
    logic [OUT_W-1:0] cell_offset;
    logic [OUT_W-1:0] cell_length;
    logic [ROW_W-1:0] row_index;
    logic [COL_W-1:0] column_index;
    logic             row_done;
    logic             file_done;
    logic             overflow;
    logic             run_last;

    modport source (output valid, cell_offset, cell_length, row_index, column_index,
                    row_done, file_done, overflow, run_last, input ready);
    modport sink   (input valid, cell_offset, cell_length, row_index, column_index,
                    row_done, file_done, overflow, run_last, output ready);
endinterface

>>> sv/tsv_cell_offset_splitter.sv
// Tab-separated cell splitter: byte stream in, one record per cell out.
//
// i_in takes one file byte per word, with end_of_data on the final byte.
// o_out gives one word per cell: offset, length, row, column and flags;
// run_last marks the last cell caused by one byte, file_done the last
// cell of the file. A valid/ready word moves when both are high.
// The front end takes one byte per cycle while the run queue has room;
// a byte that closes a cell queues one run (the closed cell plus any
// padding cells of a short row) in a 4-entry queue. The back end emits
// one cell per cycle from that queue while o_out is not stalled. Bytes
// that close no cell produce nothing. The first cell of a byte passes
// through the run queue and the output register to o_out. Input ready
// drops only while the run queue is full, e.g. during long padding
// bursts or while the receiver stalls o_out.
// Reset (synchronous, active low) clears the parse state to the start
// of a file and empties the queue and the output register; end_of_data
// also returns the parse state to the start of a file.
module tsv_cell_offset_splitter #(
    parameter int MAX_COLUMNS = tsvs_pkg::DEF_MAX_COLUMNS,
    parameter int OFFSET_BITS = tsvs_pkg::DEF_OFFSET_BITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tsvs_in_if.sink    i_in,
    tsvs_out_if.source o_out
);
    import tsvs_pkg::*;

    logic push, pop, full, empty;
    t_cmd wr_cmd, rd_cmd;

    tsvs_front #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (full),
        .o_push  (push),
        .o_cmd   (wr_cmd)
    );

    tsvs_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (wr_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_cmd   (rd_cmd),
        .o_empty (empty)
    );

    tsvs_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (rd_cmd),
        .i_empty (empty),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

>>> sv/tsvs_front.sv
// Front end: parses bytes, tracks row/column/offset state, queues cell runs.
module tsvs_front #(
    parameter int MAX_COLUMNS = tsvs_pkg::DEF_MAX_COLUMNS,
    parameter int OFFSET_BITS = tsvs_pkg::DEF_OFFSET_BITS
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    tsvs_in_if.sink        i_in,
    input  logic           i_full,
    output logic           o_push,
    output tsvs_pkg::t_cmd o_cmd
);
    import tsvs_pkg::*;

    localparam logic [WID_W-1:0] MaxCols = WID_W'(MAX_COLUMNS);

    logic [OFFSET_BITS-1:0] r_byte_offset, n_byte_offset;
    logic [OFFSET_BITS-1:0] r_cell_start, n_cell_start;
    logic [COL_W-1:0]       r_col, n_col;
    logic [WID_W-1:0]       r_width, n_width;
    logic                   r_known, n_known;
    logic [ROW_W-1:0]       r_row, n_row;
    logic                   r_cr, n_cr;
    logic                   r_ovf, n_ovf;

    logic                   accept;
    logic                   sat;
    logic [OFFSET_BITS-1:0] nxt;
    logic [OFFSET_BITS-1:0] cs;
    logic [WID_W-1:0]       col1;
    logic [WID_W-1:0]       w2;
    logic                   clamp;
    logic                   known2;
    logic                   full;
    logic [ROW_W-1:0]       row_next;
    logic [7:0]             b;

    assign i_in.ready = !i_full;
    assign accept     = i_in.valid && !i_full;
    assign b          = i_in.data_byte;

    always_comb begin
        n_byte_offset = r_byte_offset;
        n_cell_start  = r_cell_start;
        n_col         = r_col;
        n_width       = r_width;
        n_known       = r_known;
        n_row         = r_row;
        n_cr          = r_cr;
        n_ovf         = r_ovf;
        o_push        = 1'b0;

        sat      = &r_byte_offset;
        nxt      = sat ? r_byte_offset : r_byte_offset + 1'b1;
        cs       = (r_cell_start > r_byte_offset) ? r_byte_offset : r_cell_start;
        col1     = {1'b0, r_col} + 1'b1;
        row_next = (r_row != '1) ? r_row + 1'b1 : r_row;
        clamp    = !r_known && (col1 >= MaxCols);
        known2   = r_known || clamp;
        w2       = clamp ? MaxCols : r_width;
        full     = known2 && (col1 >= w2);

        o_cmd.head_off   = OUT_W'(cs);
        o_cmd.head_len   = OUT_W'(r_byte_offset - cs);
        o_cmd.pad_off    = OUT_W'(nxt);
        o_cmd.row        = r_row;
        o_cmd.head_col   = r_col;
        o_cmd.pad_col    = col1[COL_W-1:0];
        o_cmd.pad_cnt    = '0;
        o_cmd.head_rdone = 1'b0;
        o_cmd.eod        = i_in.end_of_data;
        o_cmd.ovf        = 1'b0;

        if (accept) begin
            n_byte_offset = nxt;
            n_ovf         = r_ovf || sat;
            n_cell_start  = cs;
            n_cr          = 1'b0;
            if (r_cr && b == CH_LF) begin
                // second half of CR LF: row already closed
                n_cell_start = nxt;
            end else if (b == CH_TAB) begin
                o_push           = 1'b1;
                n_known          = known2;
                n_width          = w2;
                n_ovf            = r_ovf || sat || clamp;
                o_cmd.head_rdone = full;
                n_cell_start     = nxt;
                if (full) begin
                    n_row = row_next;
                    n_col = '0;
                end else begin
                    n_col = col1[COL_W-1:0];
                    if (i_in.end_of_data) begin
                        // empty cell after the tab, then padding
                        o_cmd.pad_cnt = known2 ? w2 - col1 : WID_W'(1);
                    end
                end
            end else if (b == CH_CR || b == CH_LF || i_in.end_of_data) begin
                o_push = 1'b1;
                if (b != CH_CR && b != CH_LF) begin
                    o_cmd.head_len = OUT_W'(nxt - cs);
                end
                if (!r_known) begin
                    n_width          = col1;
                    n_known          = 1'b1;
                    o_cmd.head_rdone = 1'b1;
                end else begin
                    o_cmd.pad_cnt    = r_width - col1;
                    o_cmd.head_rdone = (col1 >= r_width);
                end
                n_row        = row_next;
                n_col        = '0;
                n_cell_start = nxt;
                n_cr         = (b == CH_CR);
            end
            o_cmd.ovf = n_ovf;

            if (i_in.end_of_data) begin
                n_byte_offset = '0;
                n_cell_start  = '0;
                n_col         = '0;
                n_width       = WID_W'(1);
                n_known       = 1'b0;
                n_row         = '0;
                n_cr          = 1'b0;
                n_ovf         = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_offset <= '0;
            r_cell_start  <= '0;
            r_col         <= '0;
            r_width       <= WID_W'(1);
            r_known       <= 1'b0;
            r_row         <= '0;
            r_cr          <= 1'b0;
            r_ovf         <= 1'b0;
        end else begin
            r_byte_offset <= n_byte_offset;
            r_cell_start  <= n_cell_start;
            r_col         <= n_col;
            r_width       <= n_width;
            r_known       <= n_known;
            r_row         <= n_row;
            r_cr          <= n_cr;
            r_ovf         <= n_ovf;
        end
    end

endmodule

>>> sv/tsvs_fifo.sv
// Short run queue between front end and cell emitter.
module tsvs_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  tsvs_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output tsvs_pkg::t_cmd o_cmd,
    output logic           o_empty
);
    import tsvs_pkg::*;

    localparam int PtrW = $clog2(QUEUE_DEPTH);
    localparam int CntW = $clog2(QUEUE_DEPTH + 1);

    t_cmd            r_mem [QUEUE_DEPTH];
    logic [PtrW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CntW-1:0] r_count;

    assign o_full  = (r_count == CntW'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

>>> sv/tsvs_back.sv
// Back end: expands runs into cells, one per cycle unless stalled.
module tsvs_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  tsvs_pkg::t_cmd i_cmd,
    input  logic           i_empty,
    output logic           o_pop,
    tsvs_out_if.source     o_out
);
    import tsvs_pkg::*;

    t_cmd             r_cmd, n_cmd;
    t_result          r_res, n_res;
    logic             r_valid, n_valid;
    logic             r_busy, n_busy;
    logic [WID_W-1:0] r_left, n_left;
    logic [COL_W-1:0] r_pcol, n_pcol;
    logic             can_load;
    logic             last;

    assign can_load = !r_valid || o_out.ready;

    always_comb begin
        n_cmd   = r_cmd;
        n_res   = r_res;
        n_valid = r_valid;
        n_busy  = r_busy;
        n_left  = r_left;
        n_pcol  = r_pcol;
        o_pop   = 1'b0;
        last    = 1'b0;
        if (can_load) begin
            if (r_busy) begin
                // padding cell
                last               = (r_left == WID_W'(1));
                n_res.cell_offset  = r_cmd.pad_off;
                n_res.cell_length  = '0;
                n_res.row_index    = r_cmd.row;
                n_res.column_index = r_pcol;
                n_res.row_done     = last;
                n_res.file_done    = r_cmd.eod && last;
                n_res.overflow     = r_cmd.ovf;
                n_res.run_last     = last;
                n_left             = r_left - 1'b1;
                n_pcol             = r_pcol + 1'b1;
                n_busy             = !last;
                n_valid            = 1'b1;
            end else if (!i_empty) begin
                o_pop              = 1'b1;
                last               = (i_cmd.pad_cnt == '0);
                n_cmd              = i_cmd;
                n_res.cell_offset  = i_cmd.head_off;
                n_res.cell_length  = i_cmd.head_len;
                n_res.row_index    = i_cmd.row;
                n_res.column_index = i_cmd.head_col;
                n_res.row_done     = i_cmd.head_rdone;
                n_res.file_done    = i_cmd.eod && last;
                n_res.overflow     = i_cmd.ovf;
                n_res.run_last     = last;
                n_left             = i_cmd.pad_cnt;
                n_pcol             = i_cmd.pad_col;
                n_busy             = !last;
                n_valid            = 1'b1;
            end else begin
                n_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_res  <= n_res;
        r_left <= n_left;
        r_pcol <= n_pcol;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_busy  <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_busy  <= n_busy;
        end
    end

    assign o_out.valid        = r_valid;
    assign o_out.cell_offset  = r_res.cell_offset;
    assign o_out.cell_length  = r_res.cell_length;
    assign o_out.row_index    = r_res.row_index;
    assign o_out.column_index = r_res.column_index;
    assign o_out.row_done     = r_res.row_done;
    assign o_out.file_done    = r_res.file_done;
    assign o_out.overflow     = r_res.overflow;
    assign o_out.run_last     = r_res.run_last;

endmodule

>>> sv/tsvs_checker.sv
// Port-level checks of the splitter, bound to the top level.
module tsvs_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_out_valid,
    input logic                      i_out_ready,
    input logic [tsvs_pkg::OUT_W-1:0] i_cell_offset,
    input logic                      i_row_done,
    input logic                      i_file_done,
    input logic                      i_run_last
);
    import tsvs_pkg::*;

    // a stalled word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_cell_offset))
        else $error("output word changed while stalled");

    a_file_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_file_done |-> i_run_last)
        else $error("file_done on a cell that is not last of its run");

    a_file_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_file_done |-> i_row_done)
        else $error("file ended without closing its row");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid right after reset");

endmodule

bind tsv_cell_offset_splitter tsvs_checker u_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_cell_offset (o_out.cell_offset),
    .i_row_done    (o_out.row_done),
    .i_file_done   (o_out.file_done),
    .i_run_last    (o_out.run_last)
);

>>> bench/tsv_cell_offset_splitter_tb.sv
// Testbench for tsv_cell_offset_splitter: directed and random TSV files checked per cell.
`timescale 1ns / 100ps

import tsvs_pkg::*;

class cell_scoreboard;
    localparam int MAX_COLS = DEF_MAX_COLUMNS;

    longint unsigned offset_cap;
    longint unsigned byte_offset;
    longint unsigned cell_start;
    int unsigned     column;
    int unsigned     width;
    bit              width_known;
    bit [ROW_W-1:0]  row;
    bit              after_cr;
    bit              overflow_seen;

    t_result cells_due[$];
    t_result run[$];
    int      errors;

    function new(int unsigned offset_bits);
        offset_cap = (64'd1 << offset_bits) - 1;
        errors     = 0;
        restart();
    endfunction

    function void restart();
        byte_offset   = 0;
        cell_start    = 0;
        column        = 0;
        width         = 1;
        width_known   = 1'b0;
        row           = '0;
        after_cr      = 1'b0;
        overflow_seen = 1'b0;
    endfunction

    function void add_cell(longint unsigned off, longint unsigned len, bit rdone);
        t_result r;
        r              = '0;
        r.cell_offset  = off[OUT_W-1:0];
        r.cell_length  = len[OUT_W-1:0];
        r.row_index    = row;
        r.column_index = column[COL_W-1:0];
        r.row_done     = rdone;
        run.push_back(r);
    endfunction

    function void advance_row();
        if (row != '1)
            row++;
        column = 0;
    endfunction

    // close the open cell as the row's last, pad short rows, open the next row
    function void close_row(longint unsigned off, longint unsigned len,
                            longint unsigned pad_off);
        int unsigned c;
        if (!width_known) begin
            width       = column + 1;
            width_known = 1'b1;
            add_cell(off, len, 1'b1);
        end else begin
            add_cell(off, len, column + 1 >= width);
            for (c = column + 1; c < width && c < MAX_COLS; c++) begin
                column = c;
                add_cell(pad_off, 0, c + 1 >= width);
            end
        end
        advance_row();
    endfunction

    function void split_byte(bit [7:0] b, bit eod);
        longint unsigned p;
        longint unsigned nxt;
        bit              full;
        run.delete();
        p = byte_offset;
        if (p >= offset_cap) begin
            p             = offset_cap;
            nxt           = offset_cap;
            overflow_seen = 1'b1;
        end else begin
            nxt = p + 1;
        end
        byte_offset = nxt;
        if (cell_start > p)
            cell_start = p;

        // LF of a CR LF pair: row already closed
        if (after_cr && b == CH_LF) begin
            after_cr   = 1'b0;
            cell_start = nxt;
            if (eod)
                restart();
            return;
        end
        after_cr = 1'b0;

        if (b == CH_TAB) begin
            if (!width_known && column + 1 >= MAX_COLS) begin
                width         = MAX_COLS;
                width_known   = 1'b1;
                overflow_seen = 1'b1;
            end
            full = width_known && column + 1 >= width;
            add_cell(cell_start, p - cell_start, full);
            cell_start = nxt;
            if (full) begin
                advance_row();
            end else begin
                column++;
                if (eod)
                    close_row(nxt, 0, nxt);
            end
        end else if (b == CH_CR || b == CH_LF) begin
            close_row(cell_start, p - cell_start, nxt);
            cell_start = nxt;
            after_cr   = (b == CH_CR);
        end else if (eod) begin
            close_row(cell_start, nxt - cell_start, nxt);
            cell_start = nxt;
        end

        foreach (run[k]) begin
            run[k].overflow  = overflow_seen;
            run[k].run_last  = (k == run.size() - 1);
            run[k].file_done = eod && (k == run.size() - 1);
            cells_due.push_back(run[k]);
        end
        if (eod)
            restart();
    endfunction

    function void compare(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    function void check_cell(t_result got);
        t_result want;
        if (cells_due.size() == 0) begin
            errors++;
            $display("%0t: cell word with nothing expected, offset %0d row %0d col %0d",
                     $time, got.cell_offset, got.row_index, got.column_index);
            return;
        end
        want = cells_due.pop_front();
        compare("cell_offset", want.cell_offset, got.cell_offset);
        compare("cell_length", want.cell_length, got.cell_length);
        compare("row_index", want.row_index, got.row_index);
        compare("column_index", want.column_index, got.column_index);
        compare("row_done", want.row_done, got.row_done);
        compare("file_done", want.file_done, got.file_done);
        compare("overflow", want.overflow, got.overflow);
        compare("run_last", want.run_last, got.run_last);
    endfunction
endclass

module tsv_cell_offset_splitter_tb;

    localparam int OFFSET_BITS  = DEF_OFFSET_BITS;
    localparam int RANDOM_BYTES = 260;
    localparam int CYCLE_LIMIT  = 3000000;

    logic i_clk = 1'b0;
    logic i_rst_n;

    tsvs_in_if  byte_ch ();
    tsvs_out_if cell_ch ();

    tsv_cell_offset_splitter #(
        .OFFSET_BITS(OFFSET_BITS)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (byte_ch),
        .o_out  (cell_ch)
    );

    cell_scoreboard sb;
    bit [8:0]       file_q[$];
    int             bytes_sent;
    int             cycles;
    bit             tx_calm;
    bit             rx_calm;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n && byte_ch.valid && byte_ch.ready)
            sb.split_byte(byte_ch.data_byte, byte_ch.end_of_data);
        if (i_rst_n && cell_ch.valid && cell_ch.ready) begin
            got.cell_offset  = cell_ch.cell_offset;
            got.cell_length  = cell_ch.cell_length;
            got.row_index    = cell_ch.row_index;
            got.column_index = cell_ch.column_index;
            got.row_done     = cell_ch.row_done;
            got.file_done    = cell_ch.file_done;
            got.overflow     = cell_ch.overflow;
            got.run_last     = cell_ch.run_last;
            sb.check_cell(got);
        end
    end

    // receiver: random stall before each cell word
    initial begin
        int stall;
        @(posedge i_rst_n);
        forever begin
            stall = rx_calm ? 0 : $urandom_range(0, 11);
            repeat (stall) @(negedge i_clk) cell_ch.ready <= 1'b0;
            @(negedge i_clk) cell_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!cell_ch.valid);
        end
    end

    function automatic bit [7:0] text_byte();
        bit [7:0] b;
        if ($urandom_range(0, 29) == 0)
            return 8'($urandom_range(0, 255));
        do b = 8'($urandom_range(0, 255)); while (b == CH_TAB || b == CH_CR || b == CH_LF);
        return b;
    endfunction

    function automatic void add_byte(bit [7:0] b);
        file_q.push_back({1'b0, b});
    endfunction

    function automatic void add_text(string s);
        foreach (s[i])
            file_q.push_back({1'b0, s[i]});
    endfunction

    task automatic send_byte(input bit [7:0] b, input bit eod);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 11);
        repeat (gap) @(negedge i_clk) byte_ch.valid <= 1'b0;
        @(negedge i_clk);
        byte_ch.valid       <= 1'b1;
        byte_ch.data_byte   <= b;
        byte_ch.end_of_data <= eod;
        do @(posedge i_clk); while (!byte_ch.ready);
    endtask

    // last byte of the queued file carries end_of_data
    task automatic send_file();
        file_q[file_q.size() - 1][8] = 1'b1;
        foreach (file_q[i])
            send_byte(file_q[i][7:0], file_q[i][8]);
        bytes_sent += file_q.size();
        file_q.delete();
    endtask

    // well-formed table with random text, some short and some overlong rows
    task automatic make_file();
        int r;
        int f;
        int cols;
        int rows;
        int fields;
        int len;
        int term;
        bit wide;
        wide = ($urandom_range(0, 24) == 0);
        cols = wide ? $urandom_range(20, 66) : $urandom_range(1, 6);
        rows = wide ? $urandom_range(1, 2) : $urandom_range(1, 5);
        for (r = 0; r < rows; r++) begin
            fields = cols;
            if (r > 0) begin
                case ($urandom_range(0, 5))
                    0: fields = $urandom_range(1, cols);
                    1: fields = cols + $urandom_range(1, 3);
                    default: fields = cols;
                endcase
            end
            for (f = 0; f < fields; f++) begin
                if (f > 0)
                    add_byte(CH_TAB);
                len = wide ? $urandom_range(0, 1) : $urandom_range(0, 4);
                repeat (len) add_byte(text_byte());
            end
            // last row may run straight into end of data
            if (r < rows - 1 || $urandom_range(0, 2) != 0) begin
                term = $urandom_range(0, 2);
                if (term != 1)
                    add_byte(CH_CR);
                if (term != 0)
                    add_byte(CH_LF);
            end
        end
        if (file_q.size() == 0)
            add_byte(text_byte());
    endtask

    initial begin
        sb                  = new(OFFSET_BITS);
        bytes_sent          = 0;
        tx_calm             = 1'b0;
        rx_calm             = 1'b0;
        i_rst_n             = 1'b0;
        byte_ch.valid       = 1'b0;
        byte_ch.data_byte   = '0;
        byte_ch.end_of_data = 1'b0;
        cell_ch.ready       = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        // CR LF, short row padding, wrap of extra fields, lone CR, open cell at end
        add_text("ab");
        add_byte(CH_TAB);
        add_text("c");
        add_byte(CH_CR);
        add_byte(CH_LF);
        add_text("d");
        add_byte(CH_LF);
        add_text("e");
        add_byte(CH_TAB);
        add_text("f");
        add_byte(CH_TAB);
        add_text("g");
        add_byte(CH_CR);
        add_text("h");
        send_file();

        // end of data on a TAB in mid row
        add_text("x");
        add_byte(CH_TAB);
        add_text("y");
        add_byte(CH_TAB);
        add_text("z");
        add_byte(CH_LF);
        add_text("p");
        add_byte(CH_TAB);
        send_file();

        // end of data on a TAB that fills the row
        add_text("a");
        add_byte(CH_TAB);
        add_text("b");
        add_byte(CH_LF);
        add_text("c");
        add_byte(CH_TAB);
        add_text("d");
        add_byte(CH_TAB);
        send_file();

        // end of data on the LF of a CR LF: no word
        add_text("a");
        add_byte(CH_CR);
        add_byte(CH_LF);
        send_file();

        add_text("u");
        add_byte(CH_CR);
        send_file();

        add_byte(8'h00);
        add_byte(8'hff);
        send_file();

        add_byte(CH_LF);
        send_file();

        add_byte(CH_TAB);
        send_file();

        // width clamp on the first line, then a row padded to the full width
        repeat (64) add_byte(CH_TAB);
        add_text("x");
        add_byte(CH_LF);
        add_text("y");
        send_file();

        bytes_sent = 0;
        while (bytes_sent < RANDOM_BYTES) begin
            tx_calm = ($urandom_range(0, 3) == 0);
            rx_calm = ($urandom_range(0, 3) == 0);
            make_file();
            send_file();
        end

        @(negedge i_clk) byte_ch.valid <= 1'b0;
        while (sb.cells_due.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

>>> files.f
sv/tsvs_pkg.sv
sv/tsvs_if.sv
sv/tsvs_front.sv
sv/tsvs_fifo.sv
sv/tsvs_back.sv
sv/tsv_cell_offset_splitter.sv
sv/tsvs_checker.sv
bench/tsv_cell_offset_splitter_tb.sv
